// ----- hdl/gss_pkg.sv -----
// Shared types, constants and phase codes for the gear shift sequencer.
package gss_pkg;

    localparam int unsigned ADC_W     = 12;
    localparam int unsigned GEAR_W    = 3;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned TORQUE_W  = 8;
    localparam int unsigned NUM_GEARS = 5;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [ADC_W:0] WINDOW_HALF = 13'd100;

    localparam logic [TICK_W-1:0] UP_ACTUATOR_TICKS   = 16'd50;
    localparam logic [TICK_W-1:0] UP_FINISH_TICKS     = 16'd200;
    localparam logic [TICK_W-1:0] DOWN_ACTUATOR_TICKS = 16'd50;
    localparam logic [TICK_W-1:0] DOWN_FINISH_TICKS   = 16'd200;
    localparam logic [TICK_W-1:0] OPEN_CLUTCH_TICKS   = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX            = 16'hffff;

    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
    localparam logic [GEAR_W-1:0] GEAR_FIRST   = 3'd1;
    localparam logic [GEAR_W-1:0] GEAR_TOP     = 3'd4;
    localparam logic [GEAR_W-1:0] GEAR_UNKNOWN = 3'd7;

    localparam logic [TORQUE_W-1:0] TORQUE_NORMAL = 8'd127;
    localparam logic [TORQUE_W-1:0] TORQUE_CUT    = 8'd255;
    localparam logic [TORQUE_W-1:0] TORQUE_MATCH  = 8'd0;

    localparam logic [ADC_W-1:0] NEUTRAL_CENTRE_RST = 12'd800;
    localparam logic [ADC_W-1:0] FIRST_CENTRE_RST   = 12'd1300;
    localparam logic [ADC_W-1:0] SECOND_CENTRE_RST  = 12'd1700;
    localparam logic [ADC_W-1:0] THIRD_CENTRE_RST   = 12'd2150;
    localparam logic [ADC_W-1:0] FOURTH_CENTRE_RST  = 12'd2550;

    typedef logic [NUM_GEARS-1:0][ADC_W-1:0] centres_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEUTRAL = 3'd0,
        CFG_FIRST   = 3'd1,
        CFG_SECOND  = 3'd2,
        CFG_THIRD   = 3'd3,
        CFG_FOURTH  = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_UP_START   = 4'd1,
        PH_UP_NEUTRAL = 4'd2,
        PH_UP_CUT     = 4'd3,
        PH_UP_FINISH  = 4'd4,
        PH_DN_START   = 4'd5,
        PH_DN_NEUTRAL = 4'd6,
        PH_DN_MATCH   = 4'd7,
        PH_DN_FINISH  = 4'd8,
        PH_OL_CLUTCH  = 4'd9,
        PH_OL_FINISH  = 4'd10
    } phase_t;

    typedef struct packed {
        logic [GEAR_W-1:0] gear;
        logic              up_req;
        logic              down_req;
    } gss_tick_t;

    typedef struct packed {
        logic [TICK_W-1:0]   last_down_time;
        logic [TICK_W-1:0]   last_up_time;
        logic                idle;
        logic [GEAR_W-1:0]   gear_now;
        logic [TORQUE_W-1:0] cut_level;
        logic                clutch_drive;
        logic                cut_drive;
        logic                down_drive;
        logic                up_drive;
    } gss_result_t;

endpackage

// ----- hdl/gear_shift_sequencer.sv -----
// Top level of the gear shift sequencer: input, classification and result stages.
// A tick item passes the input and classification registers before its result appears.
// Throughput: one tick item per cycle unless m_tready stalls; the sequencer steps once
// as each item moves from the classification register into the result register.
// Reset (rst_n, asynchronous): pipeline empty, window centres at their defaults,
// sequencer idle with gear unknown, outputs released and torque level normal.
module gear_shift_sequencer
    import gss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // gear_adc[11:0], up_request, down_request
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // up_drive, down_drive, cut_drive,
                                            // clutch_drive, cut_level[7:0],
                                            // gear_now[2:0], idle,
                                            // last_up_time[15:0], last_down_time[15:0]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADC_W-1:0]     cfg_data
);

    centres_t          centres_reg;
    logic              in_valid_reg;
    logic [ADC_W-1:0]  adc_reg;
    logic              in_up_reg;
    logic              in_down_reg;
    logic              cls_valid_reg;
    gss_tick_t         cls_reg;
    logic              out_valid_reg;
    logic [GEAR_W-1:0] gear;
    logic              out_free;
    logic              adv_cls;
    logic              cls_free;
    logic              adv_in;
    gss_result_t       result;

    assign out_free = !out_valid_reg || m_tready;
    assign adv_cls  = cls_valid_reg && out_free;
    assign cls_free = !cls_valid_reg || adv_cls;
    assign adv_in   = in_valid_reg && cls_free;
    assign s_tready = !in_valid_reg || adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centres_reg[CFG_NEUTRAL] <= NEUTRAL_CENTRE_RST;
            centres_reg[CFG_FIRST]   <= FIRST_CENTRE_RST;
            centres_reg[CFG_SECOND]  <= SECOND_CENTRE_RST;
            centres_reg[CFG_THIRD]   <= THIRD_CENTRE_RST;
            centres_reg[CFG_FOURTH]  <= FOURTH_CENTRE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEUTRAL: centres_reg[CFG_NEUTRAL] <= cfg_data;
                CFG_FIRST:   centres_reg[CFG_FIRST]   <= cfg_data;
                CFG_SECOND:  centres_reg[CFG_SECOND]  <= cfg_data;
                CFG_THIRD:   centres_reg[CFG_THIRD]   <= cfg_data;
                CFG_FOURTH:  centres_reg[CFG_FOURTH]  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cls_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cls_free)
            begin
                cls_valid_reg <= in_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= cls_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            adc_reg     <= s_tdata[11:0];
            in_up_reg   <= s_tdata[12];
            in_down_reg <= s_tdata[13];
        end
        if (adv_in)
        begin
            cls_reg.gear     <= gear;
            cls_reg.up_req   <= in_up_reg;
            cls_reg.down_req <= in_down_reg;
        end
    end

    gss_classify u_classify (
        .adc     (adc_reg),
        .centres (centres_reg),
        .gear    (gear)
    );

    gss_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv_cls),
        .tick   (cls_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result.last_down_time, result.last_up_time, result.idle,
                       result.gear_now, result.cut_level, result.clutch_drive,
                       result.cut_drive, result.down_drive, result.up_drive};

endmodule

// ----- hdl/gss_classify.sv -----
// Gear window classifier: maps one position sample to a gear code.
module gss_classify
    import gss_pkg::*;
(
    input  logic [ADC_W-1:0]  adc,
    input  centres_t          centres,
    output logic [GEAR_W-1:0] gear
);

    logic [NUM_GEARS-1:0] hit;

    always_comb
    begin
        for (int g = 0; g < NUM_GEARS; g++)
        begin
            hit[g] = (({1'b0, adc} + WINDOW_HALF) >= {1'b0, centres[g]}) &&
                     ({1'b0, adc} <= ({1'b0, centres[g]} + WINDOW_HALF));
        end
    end

    // The lowest matching gear wins.
    always_comb
    begin
        gear = GEAR_UNKNOWN;
        for (int g = NUM_GEARS - 1; g >= 0; g--)
        begin
            if (hit[g])
            begin
                gear = GEAR_W'(g);
            end
        end
    end

endmodule

// ----- hdl/gss_seq.sv -----
// Shift sequencer: phase state machine, tick counters and result register.
module gss_seq
    import gss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  gss_tick_t   tick,
    output gss_result_t result
);

    phase_t              phase_reg, phase_next;
    logic [GEAR_W-1:0]   gear_reg, gear_next;
    logic [GEAR_W-1:0]   origin_reg, origin_next;
    logic [TICK_W-1:0]   phase_ticks_reg, phase_ticks_next;
    logic [TICK_W-1:0]   shift_ticks_reg, shift_ticks_next;
    logic [TICK_W-1:0]   up_dur_reg, up_dur_next;
    logic [TICK_W-1:0]   down_dur_reg, down_dur_next;
    logic                up_pin_reg, up_pin_next;
    logic                down_pin_reg, down_pin_next;
    logic                cut_pin_reg, cut_pin_next;
    logic                clutch_drv_reg, clutch_drv_next;
    logic [TORQUE_W-1:0] torque_reg, torque_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            gear_reg        <= GEAR_UNKNOWN;
            origin_reg      <= GEAR_UNKNOWN;
            phase_ticks_reg <= '0;
            shift_ticks_reg <= '0;
            up_dur_reg      <= '0;
            down_dur_reg    <= '0;
            up_pin_reg      <= 1'b0;
            down_pin_reg    <= 1'b0;
            cut_pin_reg     <= 1'b0;
            clutch_drv_reg  <= 1'b0;
            torque_reg      <= TORQUE_NORMAL;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            gear_reg        <= gear_next;
            origin_reg      <= origin_next;
            phase_ticks_reg <= phase_ticks_next;
            shift_ticks_reg <= shift_ticks_next;
            up_dur_reg      <= up_dur_next;
            down_dur_reg    <= down_dur_next;
            up_pin_reg      <= up_pin_next;
            down_pin_reg    <= down_pin_next;
            cut_pin_reg     <= cut_pin_next;
            clutch_drv_reg  <= clutch_drv_next;
            torque_reg      <= torque_next;
        end
    end

    always_comb
    begin
        phase_t            ph;
        logic [TICK_W-1:0] pt;
        logic [GEAR_W:0]   gear_x;
        logic [GEAR_W:0]   origin_x;

        pt = (phase_ticks_reg == TICK_MAX) ? TICK_MAX : phase_ticks_reg + 16'd1;
        shift_ticks_next = (shift_ticks_reg == TICK_MAX) ? TICK_MAX
                                                         : shift_ticks_reg + 16'd1;
        gear_next        = tick.gear;
        origin_next      = origin_reg;
        up_dur_next      = up_dur_reg;
        down_dur_next    = down_dur_reg;
        up_pin_next      = up_pin_reg;
        down_pin_next    = down_pin_reg;
        cut_pin_next     = cut_pin_reg;
        clutch_drv_next  = clutch_drv_reg;
        torque_next      = torque_reg;
        phase_ticks_next = pt;

        ph = phase_reg;
        if (phase_reg == PH_IDLE)
        begin
            if (tick.up_req)
            begin
                ph = PH_UP_START;
            end
            else if (tick.down_req)
            begin
                ph = PH_DN_START;
            end
        end
        phase_next = ph;

        gear_x   = {1'b0, tick.gear};
        origin_x = {1'b0, origin_reg};

        case (ph)
            PH_IDLE:
            begin
            end
            PH_UP_START:
            begin
                origin_next      = tick.gear;
                shift_ticks_next = '0;
                phase_ticks_next = '0;
                if (tick.gear == GEAR_TOP)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    up_pin_next = 1'b1;
                    phase_next  = (tick.gear == GEAR_NEUTRAL) ? PH_UP_NEUTRAL : PH_UP_CUT;
                end
            end
            PH_UP_NEUTRAL:
            begin
                if (tick.gear == GEAR_FIRST || pt >= UP_FINISH_TICKS)
                begin
                    up_pin_next      = 1'b0;
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                end
            end
            PH_UP_CUT:
            begin
                if (pt >= UP_ACTUATOR_TICKS || tick.gear == GEAR_UNKNOWN)
                begin
                    cut_pin_next     = 1'b1;
                    torque_next      = TORQUE_CUT;
                    phase_next       = PH_UP_FINISH;
                    phase_ticks_next = '0;
                end
            end
            PH_UP_FINISH:
            begin
                if (gear_x == origin_x + 4'd1 || pt >= UP_FINISH_TICKS)
                begin
                    cut_pin_next     = 1'b0;
                    up_pin_next      = 1'b0;
                    torque_next      = TORQUE_NORMAL;
                    up_dur_next      = shift_ticks_next;
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                end
            end
            PH_DN_START:
            begin
                origin_next      = tick.gear;
                shift_ticks_next = '0;
                phase_ticks_next = '0;
                if (tick.gear > GEAR_TOP)
                begin
                    down_pin_next = 1'b1;
                    phase_next    = PH_OL_CLUTCH;
                end
                else if (tick.gear == GEAR_NEUTRAL)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    down_pin_next = 1'b1;
                    phase_next    = (tick.gear == GEAR_FIRST) ? PH_DN_NEUTRAL : PH_DN_MATCH;
                end
            end
            PH_DN_NEUTRAL:
            begin
                if (tick.gear == GEAR_NEUTRAL || pt >= DOWN_FINISH_TICKS)
                begin
                    down_pin_next    = 1'b0;
                    down_dur_next    = shift_ticks_next;
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                end
            end
            PH_DN_MATCH:
            begin
                if (pt >= DOWN_ACTUATOR_TICKS || tick.gear == GEAR_UNKNOWN)
                begin
                    clutch_drv_next  = 1'b1;
                    torque_next      = TORQUE_MATCH;
                    phase_next       = PH_DN_FINISH;
                    phase_ticks_next = '0;
                end
            end
            PH_DN_FINISH:
            begin
                if ((origin_reg != GEAR_NEUTRAL && gear_x == origin_x - 4'd1) ||
                    pt >= DOWN_FINISH_TICKS)
                begin
                    clutch_drv_next  = 1'b0;
                    down_pin_next    = 1'b0;
                    torque_next      = TORQUE_NORMAL;
                    down_dur_next    = shift_ticks_next;
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                end
            end
            PH_OL_CLUTCH:
            begin
                if (pt >= DOWN_ACTUATOR_TICKS)
                begin
                    clutch_drv_next  = 1'b1;
                    torque_next      = TORQUE_MATCH;
                    phase_next       = PH_OL_FINISH;
                    phase_ticks_next = '0;
                end
            end
            PH_OL_FINISH:
            begin
                if (pt >= OPEN_CLUTCH_TICKS)
                begin
                    clutch_drv_next  = 1'b0;
                    down_pin_next    = 1'b0;
                    torque_next      = TORQUE_NORMAL;
                    down_dur_next    = shift_ticks_next;
                    phase_next       = PH_IDLE;
                    phase_ticks_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.up_drive       = up_pin_reg;
        result.down_drive     = down_pin_reg;
        result.cut_drive      = cut_pin_reg;
        result.clutch_drive   = clutch_drv_reg;
        result.cut_level      = torque_reg;
        result.gear_now       = gear_reg;
        result.idle           = (phase_reg == PH_IDLE);
        result.last_up_time   = up_dur_reg;
        result.last_down_time = down_dur_reg;
    end

endmodule
